// File: hdl/lidar_uart_frame_parser_core_macros.svh
`ifndef LIDAR_UART_FRAME_PARSER_CORE_MACROS_SVH
`define LIDAR_UART_FRAME_PARSER_CORE_MACROS_SVH

// Both macros use the clk and arst_n of the module in which they stand.
`define LUFP_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

`define LUFP_ASSERT_NEXT(name, pre, post, msg) \
	`LUFP_ASSERT(name, (pre) |=> (post), msg)

`endif

// File: hdl/lufp_pkg.sv
`default_nettype none

package lufp_pkg;

	localparam logic [7:0]  HDR_BYTE         = 8'h59;
	localparam logic [7:0]  HDR_SUM          = 8'hB2;
	localparam logic [3:0]  LAST_PHASE       = 4'd8;
	localparam logic [15:0] MIN_STRENGTH_RST = 16'd100;
	localparam logic [7:0]  MAX_FAILURES_RST = 8'd10;

	typedef enum logic [2:0] {
		STATUS_NONE    = 3'd0,
		STATUS_ACCEPT  = 3'd1,
		STATUS_WEAK    = 3'd2,
		STATUS_BAD_SUM = 3'd3,
		STATUS_BAD_HDR = 3'd4
	} status_t;

	typedef enum logic {
		CFG_MIN_STRENGTH = 1'b0,
		CFG_MAX_FAILURES = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [15:0] min_strength;
		logic [7:0]  max_failures;
	} cfg_t;

	typedef struct packed {
		logic [15:0] distance_cm;
		logic        lost;
		status_t     frame_status;
		logic [15:0] frame_strength;
	} result_t;

endpackage

`default_nettype wire

// File: hdl/lufp_parser.sv
`default_nettype none
`include "lidar_uart_frame_parser_core_macros.svh"

module lufp_parser (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire lufp_pkg::cfg_t   cfg,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [7:0]       in_byte,
	output logic                  res_valid,
	input  wire logic             res_ready,
	output lufp_pkg::result_t     res
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              fire;

	logic [3:0]        phase_q, phase_d;
	logic [7:0]        sum_q, sum_d;
	logic [15:0]       dist_q, dist_d;
	logic [15:0]       pend_q, pend_d;
	logic [15:0]       strength_q, strength_d;
	logic [15:0]       pub_q, pub_d;
	logic              lost_q, lost_d;
	logic [8:0]        fail_q, fail_d;
	lufp_pkg::status_t status_d;

	assign in_ready  = !valid_s1 || res_ready;
	assign fire      = valid_s1 && res_ready;
	assign res_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	always_comb begin
		phase_d    = phase_q;
		sum_d      = sum_q;
		dist_d     = dist_q;
		pend_d     = pend_q;
		strength_d = strength_q;
		pub_d      = pub_q;
		lost_d     = lost_q;
		fail_d     = fail_q;
		status_d   = lufp_pkg::STATUS_NONE;
		if (phase_q == 4'd0 || phase_q > lufp_pkg::LAST_PHASE) begin
			phase_d = (byte_s1 == lufp_pkg::HDR_BYTE) ? 4'd1 : 4'd0;
		end else if (phase_q == 4'd1) begin
			if (byte_s1 == lufp_pkg::HDR_BYTE) begin
				sum_d   = lufp_pkg::HDR_SUM;
				phase_d = 4'd2;
			end else begin
				fail_d   = fail_q + 9'd1;
				status_d = lufp_pkg::STATUS_BAD_HDR;
				phase_d  = 4'd0;
			end
		end else if (phase_q < lufp_pkg::LAST_PHASE) begin
			sum_d = sum_q + byte_s1;
			case (phase_q)
				4'd2: dist_d[7:0]  = byte_s1;
				4'd3: dist_d[15:8] = byte_s1;
				4'd4: pend_d[7:0]  = byte_s1;
				4'd5: pend_d[15:8] = byte_s1;
				default: ;
			endcase
			phase_d = phase_q + 4'd1;
		end else begin
			strength_d = pend_q;
			if (sum_q != byte_s1) begin
				fail_d   = fail_q + 9'd1;
				status_d = lufp_pkg::STATUS_BAD_SUM;
			end else if (pend_q >= cfg.min_strength) begin
				pub_d    = dist_q;
				fail_d   = 9'd0;
				lost_d   = 1'b0;
				status_d = lufp_pkg::STATUS_ACCEPT;
			end else begin
				fail_d   = fail_q + 9'd1;
				status_d = lufp_pkg::STATUS_WEAK;
			end
			phase_d = 4'd0;
		end
		if (fail_d > {1'b0, cfg.max_failures}) begin
			lost_d = 1'b1;
			fail_d = {1'b0, cfg.max_failures} + 9'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= 4'd0;
			sum_q      <= 8'd0;
			strength_q <= 16'd0;
			pub_q      <= 16'd0;
			lost_q     <= 1'b0;
			fail_q     <= 9'd0;
		end else if (fire) begin
			phase_q    <= phase_d;
			sum_q      <= sum_d;
			strength_q <= strength_d;
			pub_q      <= pub_d;
			lost_q     <= lost_d;
			fail_q     <= fail_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			dist_q <= dist_d;
			pend_q <= pend_d;
		end
	end

	assign res.distance_cm    = pub_d;
	assign res.lost           = lost_d;
	assign res.frame_status   = status_d;
	assign res.frame_strength = strength_d;

	`LUFP_ASSERT_NEXT(a_accept_clears, fire && status_d == lufp_pkg::STATUS_ACCEPT,
		fail_q == 9'd0 && !lost_q, "Accepted frame did not clear the failure state.")
	`LUFP_ASSERT(a_lost_has_count, lost_q |-> fail_q != 9'd0,
		"Lost flag is set with a zero failure count.")
	`LUFP_ASSERT(a_quiet_mid_frame,
		(fire && phase_q != 4'd1 && phase_q != lufp_pkg::LAST_PHASE)
		|-> status_d == lufp_pkg::STATUS_NONE,
		"A frame status was reported away from a frame boundary.")

endmodule

`default_nettype wire

// File: hdl/lufp_out_buf.sv
`default_nettype none
`include "lidar_uart_frame_parser_core_macros.svh"

module lufp_out_buf (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire lufp_pkg::result_t in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output lufp_pkg::result_t      out_data
);

	logic              out_valid_q;
	logic              skid_valid_q;
	lufp_pkg::result_t out_data_q;
	lufp_pkg::result_t skid_data_q;
	logic              out_free;

	assign in_ready  = !skid_valid_q;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_valid;
			end
		end else if (in_valid && in_ready) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
			end else if (in_valid) begin
				out_data_q <= in_data;
			end
		end else if (in_valid && in_ready) begin
			skid_data_q <= in_data;
		end
	end

	`LUFP_ASSERT(a_skid_behind_out, skid_valid_q |-> out_valid_q,
		"Skid stage holds a result while the output stage is empty.")
	`LUFP_ASSERT_NEXT(a_stall_to_skid, in_valid && in_ready && out_valid_q && !out_ready,
		skid_valid_q, "A transaction taken during a stall was not parked.")

endmodule

`default_nettype wire

// File: hdl/lidar_uart_frame_parser_core.sv
// An accepted byte is registered in the parser, its result then in the output buffer.
// Throughput: one byte per cycle unless the skid stage is full; every accepted byte
// yields exactly one result.
// The output register and its skid stage let a byte be taken while a result waits.
// Reset (arst_n low, asynchronous) returns the parser to header search, clears the
// distance, strength, failure count and lost flag, and restores the register defaults.
`default_nettype none

module lidar_uart_frame_parser_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,   // [15:0] distance_cm, [31:16] frame_strength
	output logic [3:0]       m_axis_tuser,   // [0] lost, [3:1] frame_status
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	lufp_pkg::cfg_t    cfg_q;
	lufp_pkg::result_t res;
	lufp_pkg::result_t out_res;
	logic              res_valid;
	logic              res_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_strength <= lufp_pkg::MIN_STRENGTH_RST;
			cfg_q.max_failures <= lufp_pkg::MAX_FAILURES_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (lufp_pkg::cfg_idx_t'(cfg_index))
				lufp_pkg::CFG_MIN_STRENGTH: cfg_q.min_strength <= cfg_data;
				lufp_pkg::CFG_MAX_FAILURES: cfg_q.max_failures <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	lufp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_byte   (s_axis_tdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	lufp_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (res_valid),
		.in_ready  (res_ready),
		.in_data   (res),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (out_res)
	);

	assign m_axis_tdata = {out_res.frame_strength, out_res.distance_cm};
	assign m_axis_tuser = {out_res.frame_status, out_res.lost};

endmodule

`default_nettype wire

// File: bench/tb.sv
`default_nettype none

module tb;

	// Scoreboard: tracks the parser state for each accepted byte and holds the results due.
	class parse_scoreboard;
		logic [15:0]       min_str;
		logic [7:0]        max_fail;
		logic [3:0]        phase;
		logic [7:0]        csum;
		logic [15:0]       dist_acc;
		logic [15:0]       pend_str;
		logic [15:0]       last_str;
		logic [15:0]       shown_dist;
		logic              lost;
		logic [8:0]        fails;
		lufp_pkg::result_t due_q[$];
		int                errors;
		int                checked;
		int                status_count[5];
		int                lost_rises;

		function new();
			min_str = lufp_pkg::MIN_STRENGTH_RST;
			max_fail = lufp_pkg::MAX_FAILURES_RST;
			phase = 4'd0;
			csum = 8'h00;
			dist_acc = 16'h0000;
			pend_str = 16'h0000;
			last_str = 16'h0000;
			shown_dist = 16'h0000;
			lost = 1'b0;
			fails = 9'd0;
			errors = 0;
			checked = 0;
			lost_rises = 0;
			foreach (status_count[i]) status_count[i] = 0;
		endfunction

		function void set_reg(lufp_pkg::cfg_idx_t idx, logic [15:0] value);
			if (idx == lufp_pkg::CFG_MIN_STRENGTH) begin
				min_str = value;
			end else begin
				max_fail = value[7:0];
			end
		endfunction

		function void note_byte(logic [7:0] b);
			lufp_pkg::result_t r;
			lufp_pkg::status_t st;
			logic              was_lost;
			st = lufp_pkg::STATUS_NONE;
			was_lost = lost;
			if (phase == 4'd0 || phase > lufp_pkg::LAST_PHASE) begin
				phase = (b == lufp_pkg::HDR_BYTE) ? 4'd1 : 4'd0;
			end else if (phase == 4'd1) begin
				if (b == lufp_pkg::HDR_BYTE) begin
					csum = lufp_pkg::HDR_SUM;
					phase = 4'd2;
				end else begin
					fails = fails + 9'd1;
					st = lufp_pkg::STATUS_BAD_HDR;
					phase = 4'd0;
				end
			end else if (phase < lufp_pkg::LAST_PHASE) begin
				csum = csum + b;
				case (phase)
					4'd2: dist_acc[7:0] = b;
					4'd3: dist_acc[15:8] = b;
					4'd4: pend_str[7:0] = b;
					4'd5: pend_str[15:8] = b;
					default: ;
				endcase
				phase = phase + 4'd1;
			end else begin
				last_str = pend_str;
				if (csum != b) begin
					fails = fails + 9'd1;
					st = lufp_pkg::STATUS_BAD_SUM;
				end else if (last_str >= min_str) begin
					shown_dist = dist_acc;
					fails = 9'd0;
					lost = 1'b0;
					st = lufp_pkg::STATUS_ACCEPT;
				end else begin
					fails = fails + 9'd1;
					st = lufp_pkg::STATUS_WEAK;
				end
				phase = 4'd0;
			end
			if (fails > {1'b0, max_fail}) begin
				lost = 1'b1;
				fails = {1'b0, max_fail} + 9'd1;
			end
			if (lost && !was_lost) lost_rises++;
			status_count[int'(st)]++;
			r.distance_cm = shown_dist;
			r.lost = lost;
			r.frame_status = st;
			r.frame_strength = last_str;
			due_q.push_back(r);
		endfunction

		function void check_result(logic [31:0] data, logic [3:0] user);
			lufp_pkg::result_t want;
			lufp_pkg::result_t got;
			got.distance_cm = data[15:0];
			got.frame_strength = data[31:16];
			got.lost = user[0];
			got.frame_status = lufp_pkg::status_t'(user[3:1]);
			if (due_q.size() == 0) begin
				$error("Result transaction with nothing outstanding: tdata %h tuser %h",
					data, user);
				errors++;
				return;
			end
			want = due_q.pop_front();
			checked++;
			if (got.distance_cm !== want.distance_cm) begin
				$error("distance_cm: expected %0d, got %0d", want.distance_cm, got.distance_cm);
				errors++;
			end
			if (got.lost !== want.lost) begin
				$error("lost: expected %0b, got %0b", want.lost, got.lost);
				errors++;
			end
			if (got.frame_status !== want.frame_status) begin
				$error("frame_status: expected %0d, got %0d", want.frame_status,
					got.frame_status);
				errors++;
			end
			if (got.frame_strength !== want.frame_strength) begin
				$error("frame_strength: expected %0d, got %0d", want.frame_strength,
					got.frame_strength);
				errors++;
			end
		endfunction

		function int pending();
			return due_q.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic [3:0]  m_axis_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [0:0]  cfg_index = 1'b0;
	logic [15:0] cfg_data = 16'h0000;

	int src_idle_pct = 35;
	int rcv_idle_pct = 75;
	int total_bytes = 0;

	parse_scoreboard sb = new();

	lidar_uart_frame_parser_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #1 clk = ~clk;

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			sb.check_result(m_axis_tdata, m_axis_tuser);
		end
	end

	function automatic logic [7:0] non_header_byte();
		logic [7:0] b;
		b = 8'($urandom);
		if (b == lufp_pkg::HDR_BYTE) b = 8'h00;
		return b;
	endfunction

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_byte(b);
		total_bytes++;
		@(negedge clk);
	endtask

	task automatic send_frame(input logic [15:0] d, input logic [15:0] s, input bit corrupt);
		logic [7:0] fb[9];
		logic [7:0] sum;
		sum = 8'h00;
		fb[0] = lufp_pkg::HDR_BYTE;
		fb[1] = lufp_pkg::HDR_BYTE;
		fb[2] = d[7:0];
		fb[3] = d[15:8];
		fb[4] = s[7:0];
		fb[5] = s[15:8];
		fb[6] = 8'($urandom);
		fb[7] = 8'($urandom);
		for (int i = 0; i < 8; i++) sum = sum + fb[i];
		fb[8] = corrupt ? sum + 8'($urandom_range(255, 1)) : sum;
		foreach (fb[i]) send_byte(fb[i]);
	endtask

	task automatic send_random_sequence();
		int          kind;
		logic [15:0] ms;
		logic [15:0] s;
		logic [15:0] d;
		kind = $urandom_range(99);
		ms = sb.min_str;
		case ($urandom_range(3))
			0: s = ms;
			1: s = (ms == 16'h0000) ? 16'h0000 : ms - 16'd1;
			2: s = 16'($urandom);
			default: s = (ms > 16'hFFCD) ? 16'hFFFF : ms + 16'($urandom_range(50));
		endcase
		case ($urandom_range(7))
			0: d = 16'h0000;
			1: d = 16'hFFFF;
			default: d = 16'($urandom);
		endcase
		if (kind < 50) begin
			send_frame(d, s, 1'b0);
		end else if (kind < 65) begin
			send_frame(d, s, 1'b1);
		end else if (kind < 80) begin
			send_byte(lufp_pkg::HDR_BYTE);
			send_byte(non_header_byte());
		end else if (kind < 90) begin
			repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
		end else begin
			send_byte(lufp_pkg::HDR_BYTE);
			send_byte(lufp_pkg::HDR_BYTE);
			repeat ($urandom_range(6, 1)) send_byte(8'($urandom));
		end
	endtask

	task automatic hold_until_empty();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (sb.pending() > 0) @(negedge clk);
	endtask

	task automatic drain_block();
		hold_until_empty();
		repeat (4) @(negedge clk);
	endtask

	task automatic run_random(input int n);
		int start;
		int seq;
		start = total_bytes;
		seq = 0;
		while (total_bytes - start < n) begin
			if (seq == 12 || $urandom_range(99) < 2) hold_until_empty();
			send_random_sequence();
			seq++;
		end
	endtask

	task automatic write_reg(input lufp_pkg::cfg_idx_t idx, input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, value);
		@(negedge clk);
	endtask

	task automatic apply_settings(input logic [15:0] ms, input logic [7:0] mf);
		write_reg(lufp_pkg::CFG_MIN_STRENGTH, ms);
		write_reg(lufp_pkg::CFG_MAX_FAILURES, {8'($urandom), mf});
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		#400000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		logic [15:0] ms;
		logic [7:0]  mf;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Stray bytes while hunting, a broken header pair, then one frame of each ending.
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(lufp_pkg::HDR_BYTE);
		send_byte(8'h58);
		send_frame(16'hFFFF, 16'hFFFF, 1'b0);
		send_frame(16'h0000, lufp_pkg::MIN_STRENGTH_RST - 16'd1, 1'b0);
		send_frame(16'h8001, lufp_pkg::MIN_STRENGTH_RST, 1'b1);
		run_random(150);

		for (int seg = 1; seg < 6; seg++) begin
			drain_block();
			if (seg < 2) begin
				src_idle_pct = 35;
				rcv_idle_pct = 75;
			end else if (seg < 4) begin
				src_idle_pct = 75;
				rcv_idle_pct = 35;
			end else begin
				src_idle_pct = 0;
				rcv_idle_pct = 0;
			end
			case (seg)
				1: begin
					ms = 16'h0000;
					mf = 8'd0;
				end
				2: begin
					ms = 16'hFFFF;
					mf = 8'd255;
				end
				3: begin
					ms = 16'($urandom);
					mf = 8'($urandom_range(20));
				end
				4: begin
					ms = 16'($urandom_range(400));
					mf = 8'($urandom);
				end
				default: begin
					ms = lufp_pkg::MIN_STRENGTH_RST;
					mf = 8'($urandom_range(5));
				end
			endcase
			apply_settings(ms, mf);
			run_random(150);
			// A long run of broken headers drives the count to its ceiling, so that
			// the smaller limit of the next setting lies below the count.
			if (seg == 2) begin
				repeat (270) begin
					send_byte(lufp_pkg::HDR_BYTE);
					send_byte(non_header_byte());
				end
			end
		end

		hold_until_empty();
		repeat (8) @(negedge clk);
		$display("Sent %0d bytes under six register settings: %0d accepted, %0d weak,",
			total_bytes, sb.status_count[lufp_pkg::STATUS_ACCEPT],
			sb.status_count[lufp_pkg::STATUS_WEAK]);
		$display("%0d bad checksum, %0d bad header; lost raised %0d times, %0d results checked.",
			sb.status_count[lufp_pkg::STATUS_BAD_SUM],
			sb.status_count[lufp_pkg::STATUS_BAD_HDR], sb.lost_rises, sb.checked);
		if (sb.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

`default_nettype wire
